/* rtl/core/bpc_pkg.sv */
// shared types, constants and multiply helpers for the pressure compensation block
`default_nettype none
package bpc_pkg;

    localparam int RawW    = 20;
    localparam int CalW    = 32;
    localparam int NumCal  = 6;
    localparam int CalIdxW = 3;
    localparam int TempW   = 24;
    localparam int TfW     = 25;
    localparam int FineW   = 32;
    localparam int PressW  = 32;
    localparam int DivW    = 64;
    localparam int RemW    = 31;
    localparam int NPre    = 12;
    localparam int NPost   = 6;

    typedef enum logic [CalIdxW-1:0] {
        CAL_T1_T2 = 3'd0,
        CAL_T3_P1 = 3'd1,
        CAL_P2_P3 = 3'd2,
        CAL_P4_P5 = 3'd3,
        CAL_P6_P7 = 3'd4,
        CAL_P8_P9 = 3'd5
    } t_cal_idx;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_cal;

    // per item context travelling along the divider row
    typedef struct packed {
        logic signed [TfW-1:0]   tf;
        logic signed [TempW-1:0] temp;
        logic                    zero;
        logic                    neg;
        logic        [RemW-1:0]  dvs;
    } t_ctx;

    // sign extend a 16 bit coefficient to a 33 bit multiplier operand
    function automatic logic [32:0] f_cx(logic signed [15:0] s);
        return {{17{s[15]}}, s};
    endfunction

    // low word times coefficient, full signed product as 64 bits
    function automatic logic [63:0] f_mlo(logic [31:0] a, logic [32:0] c);
        logic signed [65:0] pr;
        pr = $signed({1'b0, a}) * $signed(c);
        return pr[63:0];
    endfunction

    // high word times coefficient, only the bits that land below 2^64
    function automatic logic [31:0] f_mhi(logic [31:0] a, logic [32:0] c);
        logic [31:0] pr;
        pr = a * c[31:0];
        return pr;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/bpc_in_if.sv */
// input channel: raw temperature and pressure conversions
`default_nettype none
interface bpc_in_if import bpc_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [RawW-1:0] raw_temp;
    logic [RawW-1:0] raw_press;

    modport source (output valid, output raw_temp, output raw_press, input ready);
    modport sink   (input valid, input raw_temp, input raw_press, output ready);
endinterface
`default_nettype wire

/* rtl/core/bpc_out_if.sv */
// output channel: compensated temperature and pressure
`default_nettype none
interface bpc_out_if import bpc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [TempW-1:0] temp_centi;
    logic signed [FineW-1:0] fine_temp;
    logic [PressW-1:0]       press_q24_8;
    logic                    press_valid;

    modport source (output valid, output temp_centi, output fine_temp,
                    output press_q24_8, output press_valid, input ready);
    modport sink   (input valid, input temp_centi, input fine_temp,
                    input press_q24_8, input press_valid, output ready);
endinterface
`default_nettype wire

/* rtl/core/bpc_pre.sv */
// temperature compensation and dividend / divisor preparation pipeline
`default_nettype none
module bpc_pre import bpc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_v,
    output logic                  o_ld,
    input  wire logic [RawW-1:0]  i_raw_temp,
    input  wire logic [RawW-1:0]  i_raw_press,
    input  wire t_cal             i_cal,
    output logic                  o_v,
    input  wire logic             i_ld,
    output t_ctx                  o_ctx,
    output logic [DivW-1:0]       o_dvd
);

    logic [NPre-1:0] r_v;
    logic [NPre-1:0] n_v;
    logic [NPre:0]   ld;

    assign ld[NPre] = i_ld;
    for (genvar k = 0; k < NPre; k++) begin : g_ld
        assign ld[k] = ~r_v[k] | ld[k+1];
    end
    assign n_v  = {r_v[NPre-2:0], i_v};
    assign o_ld = ld[0];
    assign o_v  = r_v[NPre-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NPre; k++) begin
                if (ld[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    // stage payload
    logic signed [17:0]      r1_a;
    logic signed [16:0]      r1_b;
    logic [20:0]             r1_p0;
    logic signed [33:0]      r2_m1;
    logic signed [33:0]      r2_bb;
    logic [20:0]             r2_p0;
    logic signed [22:0]      r3_v1;
    logic signed [37:0]      r3_m3;
    logic [20:0]             r3_p0;
    logic signed [TfW-1:0]   r4_tf;
    logic [20:0]             r4_p0;
    logic signed [TfW-1:0]   r5_tf;
    logic signed [TempW-1:0] r5_temp;
    logic signed [25:0]      r5_x;
    logic [20:0]             r5_p0;
    logic signed [TfW-1:0]   r6_tf;
    logic signed [TempW-1:0] r6_temp;
    logic signed [51:0]      r6_xx;
    logic signed [41:0]      r6_xp5;
    logic signed [41:0]      r6_xp2;
    logic [20:0]             r6_p0;
    logic signed [TfW-1:0]   r7_tf;
    logic signed [TempW-1:0] r7_temp;
    logic [63:0]             r7_a6;
    logic [31:0]             r7_h6;
    logic [63:0]             r7_a3;
    logic [31:0]             r7_h3;
    logic signed [41:0]      r7_xp5;
    logic signed [41:0]      r7_xp2;
    logic [20:0]             r7_p0;
    logic signed [TfW-1:0]   r8_tf;
    logic signed [TempW-1:0] r8_temp;
    logic [63:0]             r8_xxp6;
    logic [63:0]             r8_xxp3;
    logic signed [41:0]      r8_xp5;
    logic signed [41:0]      r8_xp2;
    logic [20:0]             r8_p0;
    logic signed [TfW-1:0]   r9_tf;
    logic signed [TempW-1:0] r9_temp;
    logic [63:0]             r9_v2;
    logic [63:0]             r9_v1a;
    logic [20:0]             r9_p0;
    logic signed [TfW-1:0]   r10_tf;
    logic signed [TempW-1:0] r10_temp;
    logic [63:0]             r10_lo;
    logic [31:0]             r10_hi;
    logic [63:0]             r10_d;
    logic signed [TfW-1:0]   r11_tf;
    logic signed [TempW-1:0] r11_temp;
    logic signed [RemW-1:0]  r11_dvs;
    logic [63:0]             r11_num;
    t_ctx                    r12_ctx;
    logic [DivW-1:0]         r12_ma;

    logic signed [21:0] n3_bbs;
    logic signed [23:0] n4_v2;
    logic signed [27:0] n5_t;
    logic [63:0]        n7_xx;
    logic [63:0]        n11_pr;
    logic [RemW-1:0]    n12_mb;

    assign n3_bbs = 22'(r2_bb >>> 12);
    assign n4_v2  = 24'(r3_m3 >>> 14);
    assign n5_t   = r4_tf * 28'sd5 + 28'sd128;
    assign n7_xx  = 64'(r6_xx);
    assign n11_pr = r10_lo + {r10_hi, 32'd0};
    assign n12_mb = r11_dvs[RemW-1] ? (31'd0 - 31'(r11_dvs)) : 31'(r11_dvs);

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r1_a  <= $signed({1'b0, i_raw_temp[19:3]}) - $signed({1'b0, i_cal.t1, 1'b0});
            r1_b  <= $signed({1'b0, i_raw_temp[19:4]}) - $signed({1'b0, i_cal.t1});
            r1_p0 <= 21'd1048576 - {1'b0, i_raw_press};
        end
        if (ld[1]) begin
            r2_m1 <= r1_a * i_cal.t2;
            r2_bb <= r1_b * r1_b;
            r2_p0 <= r1_p0;
        end
        if (ld[2]) begin
            r3_v1 <= 23'(r2_m1 >>> 11);
            r3_m3 <= n3_bbs * i_cal.t3;
            r3_p0 <= r2_p0;
        end
        if (ld[3]) begin
            r4_tf <= r3_v1 + n4_v2;
            r4_p0 <= r3_p0;
        end
        if (ld[4]) begin
            r5_tf   <= r4_tf;
            r5_temp <= 24'(n5_t >>> 8);
            r5_x    <= r4_tf - 26'sd128000;
            r5_p0   <= r4_p0;
        end
        if (ld[5]) begin
            r6_tf   <= r5_tf;
            r6_temp <= r5_temp;
            r6_xx   <= r5_x * r5_x;
            r6_xp5  <= r5_x * i_cal.p5;
            r6_xp2  <= r5_x * i_cal.p2;
            r6_p0   <= r5_p0;
        end
        // x*x times p6 and p3, split in word halves
        if (ld[6]) begin
            r7_tf   <= r6_tf;
            r7_temp <= r6_temp;
            r7_a6   <= f_mlo(n7_xx[31:0], f_cx(i_cal.p6));
            r7_h6   <= f_mhi(n7_xx[63:32], f_cx(i_cal.p6));
            r7_a3   <= f_mlo(n7_xx[31:0], f_cx(i_cal.p3));
            r7_h3   <= f_mhi(n7_xx[63:32], f_cx(i_cal.p3));
            r7_xp5  <= r6_xp5;
            r7_xp2  <= r6_xp2;
            r7_p0   <= r6_p0;
        end
        if (ld[7]) begin
            r8_tf   <= r7_tf;
            r8_temp <= r7_temp;
            r8_xxp6 <= r7_a6 + {r7_h6, 32'd0};
            r8_xxp3 <= r7_a3 + {r7_h3, 32'd0};
            r8_xp5  <= r7_xp5;
            r8_xp2  <= r7_xp2;
            r8_p0   <= r7_p0;
        end
        if (ld[8]) begin
            r9_tf   <= r8_tf;
            r9_temp <= r8_temp;
            r9_v2   <= r8_xxp6 + (64'(r8_xp5) << 17) + (64'(i_cal.p4) << 35);
            r9_v1a  <= 64'h0000_8000_0000_0000 + 64'($signed(r8_xxp3) >>> 8)
                       + (64'(r8_xp2) << 12);
            r9_p0   <= r8_p0;
        end
        if (ld[9]) begin
            r10_tf   <= r9_tf;
            r10_temp <= r9_temp;
            r10_lo   <= f_mlo(r9_v1a[31:0], {17'd0, i_cal.p1});
            r10_hi   <= f_mhi(r9_v1a[63:32], {17'd0, i_cal.p1});
            r10_d    <= {12'd0, r9_p0, 31'd0} - r9_v2;
        end
        if (ld[10]) begin
            r11_tf   <= r10_tf;
            r11_temp <= r10_temp;
            r11_dvs  <= n11_pr[63:33];
            r11_num  <= 64'(r10_d * 64'd3125);
        end
        // magnitudes for the unsigned divider row
        if (ld[11]) begin
            r12_ctx.tf   <= r11_tf;
            r12_ctx.temp <= r11_temp;
            r12_ctx.zero <= (r11_dvs == '0);
            r12_ctx.neg  <= r11_num[63] ^ r11_dvs[RemW-1];
            r12_ctx.dvs  <= n12_mb;
            r12_ma       <= r11_num[63] ? (64'd0 - r11_num) : r11_num;
        end
    end

    assign o_ctx = r12_ctx;
    assign o_dvd = r12_ma;

endmodule
`default_nettype wire

/* rtl/core/bpc_div_cell.sv */
// one restoring divider cell: takes one dividend bit, yields one quotient bit
`default_nettype none
module bpc_div_cell import bpc_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_v,
    output logic                 o_ld,
    input  wire t_ctx            i_ctx,
    input  wire logic [DivW-1:0] i_dq,
    input  wire logic [RemW-1:0] i_rem,
    output logic                 o_v,
    input  wire logic            i_ld,
    output t_ctx                 o_ctx,
    output logic [DivW-1:0]      o_dq,
    output logic [RemW-1:0]      o_rem
);

    logic            r_v;
    t_ctx            r_ctx;
    logic [DivW-1:0] r_dq;
    logic [RemW-1:0] r_rem;

    logic [RemW:0]   n_trial;
    logic [RemW:0]   n_diff;
    logic            n_ge;

    // dq holds the unused dividend bits on top and the quotient bits below
    assign n_trial = {i_rem, i_dq[DivW-1]};
    assign n_diff  = n_trial - {1'b0, i_ctx.dvs};
    assign n_ge    = (n_trial >= {1'b0, i_ctx.dvs});
    assign o_ld    = ~r_v | i_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ld) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ld) begin
            r_ctx <= i_ctx;
            r_dq  <= {i_dq[DivW-2:0], n_ge};
            r_rem <= n_ge ? n_diff[RemW-1:0] : n_trial[RemW-1:0];
        end
    end

    assign o_v   = r_v;
    assign o_ctx = r_ctx;
    assign o_dq  = r_dq;
    assign o_rem = r_rem;

endmodule
`default_nettype wire

/* rtl/core/bpc_post.sv */
// quotient sign, second order pressure terms, offset and clamp
`default_nettype none
module bpc_post import bpc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_v,
    output logic                  o_ld,
    input  wire t_ctx             i_ctx,
    input  wire logic [DivW-1:0]  i_quo,
    input  wire t_cal             i_cal,
    output logic                  o_v,
    input  wire logic             i_ld,
    output logic signed [TempW-1:0] o_temp,
    output logic signed [FineW-1:0] o_fine,
    output logic [PressW-1:0]     o_press,
    output logic                  o_press_ok
);

    logic [NPost-1:0] r_v;
    logic [NPost-1:0] n_v;
    logic [NPost:0]   ld;

    assign ld[NPost] = i_ld;
    for (genvar k = 0; k < NPost; k++) begin : g_ld
        assign ld[k] = ~r_v[k] | ld[k+1];
    end
    assign n_v  = {r_v[NPost-2:0], i_v};
    assign o_ld = ld[0];
    assign o_v  = r_v[NPost-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NPost; k++) begin
                if (ld[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    t_ctx        r1_ctx;
    logic [63:0] r1_p;
    t_ctx        r2_ctx;
    logic [63:0] r2_p;
    logic [63:0] r2_qql;
    logic [31:0] r2_qqx;
    logic [63:0] r2_e2l;
    logic [31:0] r2_e2h;
    t_ctx        r3_ctx;
    logic [63:0] r3_p;
    logic [63:0] r3_qq;
    logic [63:0] r3_e2;
    t_ctx        r4_ctx;
    logic [63:0] r4_p;
    logic [63:0] r4_e2;
    logic [63:0] r4_e1l;
    logic [31:0] r4_e1h;
    t_ctx        r5_ctx;
    logic [63:0] r5_s;
    logic signed [TempW-1:0] r6_temp;
    logic signed [FineW-1:0] r6_fine;
    logic [PressW-1:0]       r6_press;
    logic                    r6_ok;

    logic [63:0] n2_q;
    logic [63:0] n3_e2p;
    logic [63:0] n5_e1p;
    logic [63:0] n6_r;

    assign n2_q   = 64'($signed(r1_p) >>> 13);
    assign n3_e2p = r2_e2l + {r2_e2h, 32'd0};
    assign n5_e1p = r4_e1l + {r4_e1h, 32'd0};
    assign n6_r   = 64'($signed(r5_s) >>> 8) + (64'(i_cal.p7) << 4);

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r1_ctx <= i_ctx;
            r1_p   <= i_ctx.neg ? (64'd0 - i_quo) : i_quo;
        end
        // q*q and p*p8 in word halves
        if (ld[1]) begin
            r2_ctx <= r1_ctx;
            r2_p   <= r1_p;
            r2_qql <= n2_q[31:0] * n2_q[31:0];
            r2_qqx <= 32'(n2_q[31:0] * n2_q[63:32]);
            r2_e2l <= f_mlo(r1_p[31:0], f_cx(i_cal.p8));
            r2_e2h <= f_mhi(r1_p[63:32], f_cx(i_cal.p8));
        end
        if (ld[2]) begin
            r3_ctx <= r2_ctx;
            r3_p   <= r2_p;
            r3_qq  <= r2_qql + {r2_qqx[30:0], 33'd0};
            r3_e2  <= 64'($signed(n3_e2p) >>> 19);
        end
        if (ld[3]) begin
            r4_ctx <= r3_ctx;
            r4_p   <= r3_p;
            r4_e2  <= r3_e2;
            r4_e1l <= f_mlo(r3_qq[31:0], f_cx(i_cal.p9));
            r4_e1h <= f_mhi(r3_qq[63:32], f_cx(i_cal.p9));
        end
        if (ld[4]) begin
            r5_ctx <= r4_ctx;
            r5_s   <= r4_p + 64'($signed(n5_e1p) >>> 25) + r4_e2;
        end
        // output register: clamp to 32 bits, zero divisor forces invalid
        if (ld[5]) begin
            r6_temp <= r5_ctx.temp;
            r6_fine <= 32'(r5_ctx.tf);
            r6_ok   <= ~r5_ctx.zero;
            priority if (r5_ctx.zero || n6_r[63]) begin
                r6_press <= '0;
            end else if (|n6_r[63:32]) begin
                r6_press <= '1;
            end else begin
                r6_press <= n6_r[31:0];
            end
        end
    end

    assign o_temp     = r6_temp;
    assign o_fine     = r6_fine;
    assign o_press    = r6_press;
    assign o_press_ok = r6_ok;

endmodule
`default_nettype wire

/* rtl/core/barometric_pressure_compensation.sv */
// top level of the barometric pressure and temperature compensation block
`default_nettype none
// Integer compensation of one raw temperature and one raw pressure reading per
// item. Six 32 bit calibration registers hold the twelve sensor coefficients;
// write them only while no item is in flight. Each item gives one result:
// temperature in 0.01 degC, the fine temperature, and pressure in Pa as
// unsigned Q24.8 (clamped to 32 bits, 0 with press_valid low when the divisor
// term is zero). The block takes one item per clock cycle while the output is
// not stalled. The divider row has 64 cells (one quotient bit per cell),
// behind 12 temperature and operand preparation stages and ahead of 6
// correction and clamp stages. Every stage holds its item only while the next
// one is full, so empty stages close up and new items are taken while a
// finished result waits on the output. There is no clearing pass after reset.
module barometric_pressure_compensation import bpc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CalIdxW-1:0] i_cfg_idx,
    input  wire logic [CalW-1:0]    i_cfg_data,
    bpc_in_if.sink                  i_item,
    bpc_out_if.source               o_res
);

    // calibration registers, reset to zero
    logic [CalW-1:0] r_cal [NumCal];
    t_cal            cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumCal; k++) begin
                r_cal[k] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cal_idx'(i_cfg_idx))
                CAL_T1_T2: r_cal[0] <= i_cfg_data;
                CAL_T3_P1: r_cal[1] <= i_cfg_data;
                CAL_P2_P3: r_cal[2] <= i_cfg_data;
                CAL_P4_P5: r_cal[3] <= i_cfg_data;
                CAL_P6_P7: r_cal[4] <= i_cfg_data;
                CAL_P8_P9: r_cal[5] <= i_cfg_data;
                default: ; // writes beyond the register list are dropped
            endcase
        end
    end

    // unpack coefficients
    always_comb begin
        cal.t1 = r_cal[0][15:0];
        cal.t2 = r_cal[0][31:16];
        cal.t3 = r_cal[1][15:0];
        cal.p1 = r_cal[1][31:16];
        cal.p2 = r_cal[2][15:0];
        cal.p3 = r_cal[2][31:16];
        cal.p4 = r_cal[3][15:0];
        cal.p5 = r_cal[3][31:16];
        cal.p6 = r_cal[4][15:0];
        cal.p7 = r_cal[4][31:16];
        cal.p8 = r_cal[5][15:0];
        cal.p9 = r_cal[5][31:16];
    end

    // handshake and payload along the divider row
    logic            row_v   [DivW+1];
    logic            row_ld  [DivW+1];
    t_ctx            row_ctx [DivW+1];
    logic [DivW-1:0] row_dq  [DivW+1];
    logic [RemW-1:0] row_rem [DivW+1];

    // temperature, divisor and dividend preparation
    bpc_pre u_pre (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_v         (i_item.valid),
        .o_ld        (i_item.ready),
        .i_raw_temp  (i_item.raw_temp),
        .i_raw_press (i_item.raw_press),
        .i_cal       (cal),
        .o_v         (row_v[0]),
        .i_ld        (row_ld[0]),
        .o_ctx       (row_ctx[0]),
        .o_dvd       (row_dq[0])
    );

    assign row_rem[0] = '0;

    // 64 cell restoring divider, most significant quotient bit first
    for (genvar k = 0; k < DivW; k++) begin : g_div
        bpc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_v     (row_v[k]),
            .o_ld    (row_ld[k]),
            .i_ctx   (row_ctx[k]),
            .i_dq    (row_dq[k]),
            .i_rem   (row_rem[k]),
            .o_v     (row_v[k+1]),
            .i_ld    (row_ld[k+1]),
            .o_ctx   (row_ctx[k+1]),
            .o_dq    (row_dq[k+1]),
            .o_rem   (row_rem[k+1])
        );
    end

    // sign fix, second order terms, clamp and output register
    bpc_post u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_v        (row_v[DivW]),
        .o_ld       (row_ld[DivW]),
        .i_ctx      (row_ctx[DivW]),
        .i_quo      (row_dq[DivW]),
        .i_cal      (cal),
        .o_v        (o_res.valid),
        .i_ld       (o_res.ready),
        .o_temp     (o_res.temp_centi),
        .o_fine     (o_res.fine_temp),
        .o_press    (o_res.press_q24_8),
        .o_press_ok (o_res.press_valid)
    );

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// testbench for the barometric pressure compensation block: table-driven and random checks
`default_nettype none
module tb_top;
    import bpc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CalIdxW-1:0] i_cfg_idx;
    logic [CalW-1:0] i_cfg_data;

    bpc_in_if  in_ch ();
    bpc_out_if out_ch ();

    barometric_pressure_compensation u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_ch.sink),
        .o_res      (out_ch.source)
    );

    // one compensated reading as the block should produce it
    typedef struct packed {
        logic signed [TempW-1:0] temp_centi;
        logic signed [FineW-1:0] fine_temp;
        logic [PressW-1:0]       press_q24_8;
        logic                    press_valid;
    } t_reading;

    // one row of the directed table; chk marks a hand-typed result
    typedef struct {
        logic [RawW-1:0] raw_temp;
        logic [RawW-1:0] raw_press;
        bit              chk;
        t_reading        res;
    } t_row;

    localparam int Latency = 82;
    localparam int NumRand = 1950;

    logic [CalW-1:0] cal_shadow [NumCal];
    t_reading        pending_readings [$];
    t_reading        typed_readings [$];
    bit              typed_flag [$];
    int              n_errors;
    int              n_results;
    int              n_items;
    bit              calm;
    bit              drain;

    // clock: period 4
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // sign extend a packed 16 bit coefficient
    function automatic logic signed [63:0] sx(logic [15:0] h);
        return {{48{h[15]}}, h};
    endfunction

    // integer compensation of one reading pair at the current calibration
    function automatic t_reading compensate(logic [RawW-1:0] rt, logic [RawW-1:0] rp);
        logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] a, b, v1, v2, tf, tc, x, p, q, e1, e2, r, num;
        t_reading res;
        t1 = {48'd0, cal_shadow[CAL_T1_T2][15:0]};
        t2 = sx(cal_shadow[CAL_T1_T2][31:16]);
        t3 = sx(cal_shadow[CAL_T3_P1][15:0]);
        p1 = {48'd0, cal_shadow[CAL_T3_P1][31:16]};
        p2 = sx(cal_shadow[CAL_P2_P3][15:0]);
        p3 = sx(cal_shadow[CAL_P2_P3][31:16]);
        p4 = sx(cal_shadow[CAL_P4_P5][15:0]);
        p5 = sx(cal_shadow[CAL_P4_P5][31:16]);
        p6 = sx(cal_shadow[CAL_P6_P7][15:0]);
        p7 = sx(cal_shadow[CAL_P6_P7][31:16]);
        p8 = sx(cal_shadow[CAL_P8_P9][15:0]);
        p9 = sx(cal_shadow[CAL_P8_P9][31:16]);
        // temperature
        a  = $signed({44'd0, rt >> 3}) - (t1 <<< 1);
        v1 = (a * t2) >>> 11;
        b  = $signed({44'd0, rt >> 4}) - t1;
        v2 = (((b * b) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        tc = (tf * 5 + 128) >>> 8;
        // pressure, all 64 bit wrapping
        x  = tf - 128000;
        v2 = x * x * p6;
        v2 = v2 + ((x * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        res.temp_centi  = tc[TempW-1:0];
        res.fine_temp   = tf[FineW-1:0];
        res.press_q24_8 = '0;
        res.press_valid = 1'b0;
        if (v1 != 0) begin
            p   = 64'sd1048576 - $signed({44'd0, rp});
            num = ((p <<< 31) - v2) * 3125;
            // the most negative dividend over -1 wraps to itself
            if (num == {1'b1, 63'd0} && v1 == -64'sd1)
                p = num;
            else
                p = num / v1;
            q  = p >>> 13;
            e1 = (p9 * q * q) >>> 25;
            e2 = (p8 * p) >>> 19;
            r  = ((p + e1 + e2) >>> 8) + (p7 <<< 4);
            if (r < 0)
                res.press_q24_8 = '0;
            else if (r > 64'sh0FFFF_FFFF)
                res.press_q24_8 = '1;
            else
                res.press_q24_8 = r[31:0];
            res.press_valid = 1'b1;
        end
        return res;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    endtask

    // result side: random stalls, checks against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || drain || ($urandom_range(99) >= 28);
            if (out_ch.valid && out_ch.ready) begin
                if (pending_readings.size() == 0) begin
                    report("unexpected item", 64'(out_ch.fine_temp), 0);
                end else begin
                    t_reading want;
                    bit       typed;
                    t_reading hand;
                    want  = pending_readings.pop_front();
                    typed = typed_flag.pop_front();
                    hand  = typed_readings.pop_front();
                    if (typed && hand != want)
                        report("table vs predictor", 64'(hand.fine_temp),
                               64'(want.fine_temp));
                    if (out_ch.temp_centi !== want.temp_centi)
                        report("temp_centi", 64'(out_ch.temp_centi), 64'(want.temp_centi));
                    if (out_ch.fine_temp !== want.fine_temp)
                        report("fine_temp", 64'(out_ch.fine_temp), 64'(want.fine_temp));
                    if (out_ch.press_q24_8 !== want.press_q24_8)
                        report("press_q24_8", 64'(out_ch.press_q24_8),
                               64'(want.press_q24_8));
                    if (out_ch.press_valid !== want.press_valid)
                        report("press_valid", 64'(out_ch.press_valid),
                               64'(want.press_valid));
                end
                n_results++;
            end
        end
    end

    // write one calibration register while the block is idle
    task automatic write_cal(t_cal_idx idx, logic [CalW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cal_shadow[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    // push one reading pair, with random idle cycles in front
    task automatic send(logic [RawW-1:0] rt, logic [RawW-1:0] rp, bit typed, t_reading hand);
        while (!calm && $urandom_range(99) < 28) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.raw_temp  <= rt;
        in_ch.raw_press <= rp;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        pending_readings.push_back(compensate(rt, rp));
        typed_flag.push_back(typed);
        typed_readings.push_back(hand);
        n_items++;
    endtask

    task automatic idle_input();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // typical sensor-like coefficient set
    task automatic load_typical();
        write_cal(CAL_T1_T2, {16'd26435, 16'd27504});
        write_cal(CAL_T3_P1, {16'd36477, 16'hFC18});
        write_cal(CAL_P2_P3, {16'd3024, 16'hD6D0});
        write_cal(CAL_P4_P5, {16'd140, 16'd2855});
        write_cal(CAL_P6_P7, {16'd15500, 16'hFFF9});
        write_cal(CAL_P8_P9, {16'd6000, 16'hC6F0});
    endtask

    task automatic load_random();
        for (int k = 0; k < NumCal; k++)
            write_cal(t_cal_idx'(k), $urandom());
    endtask

    t_row     dir_rows [$];
    t_reading zero_res;
    t_reading none_res;
    int       phase;

    initial begin
        n_errors = 0; n_results = 0; n_items = 0;
        calm = 1'b0; drain = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.raw_temp = '0; in_ch.raw_press = '0;
        for (int k = 0; k < NumCal; k++)
            cal_shadow[k] = '0;
        none_res = '0;
        // after reset every coefficient is 0: fine temp 0, temp 0 (128>>8), divisor 0
        zero_res = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset calibration: extremes of the raw fields
        dir_rows.push_back('{20'd0, 20'd0, 1'b1, zero_res});
        dir_rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b1, zero_res});
        dir_rows.push_back('{20'hAAAAA, 20'h55555, 1'b1, zero_res});
        dir_rows.push_back('{20'h55555, 20'hAAAAA, 1'b1, zero_res});
        foreach (dir_rows[k])
            send(dir_rows[k].raw_temp, dir_rows[k].raw_press, dir_rows[k].chk,
                 dir_rows[k].res);
        idle_input();
        wait_idle();
        dir_rows.delete();

        // typical calibration: normal pressures, raw extremes, clamp cases
        load_typical();
        dir_rows.push_back('{20'd519888, 20'd415148, 1'b0, none_res});
        dir_rows.push_back('{20'd0, 20'd0, 1'b0, none_res});
        dir_rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b0, none_res});
        dir_rows.push_back('{20'd0, 20'hFFFFF, 1'b0, none_res});
        dir_rows.push_back('{20'hFFFFF, 20'd0, 1'b0, none_res});
        dir_rows.push_back('{20'd423000, 20'd300000, 1'b0, none_res});
        foreach (dir_rows[k])
            send(dir_rows[k].raw_temp, dir_rows[k].raw_press, 1'b0, none_res);
        idle_input();
        wait_idle();

        // extreme coefficients: all ones, all most negative, then max positive
        for (int k = 0; k < NumCal; k++)
            write_cal(t_cal_idx'(k), 32'hFFFFFFFF);
        send(20'd0, 20'd0, 1'b0, none_res);
        send(20'hFFFFF, 20'hFFFFF, 1'b0, none_res);
        send(20'h80000, 20'd1, 1'b0, none_res);
        idle_input();
        wait_idle();
        for (int k = 0; k < NumCal; k++)
            write_cal(t_cal_idx'(k), 32'h80008000);
        send(20'd0, 20'hFFFFF, 1'b0, none_res);
        send(20'hFFFFF, 20'd0, 1'b0, none_res);
        idle_input();
        wait_idle();
        for (int k = 0; k < NumCal; k++)
            write_cal(t_cal_idx'(k), 32'h7FFF7FFF);
        send(20'd12345, 20'd54321, 1'b0, none_res);
        send(20'hFFFFF, 20'hFFFFF, 1'b0, none_res);
        idle_input();
        wait_idle();

        // random part in phases: typical calibration, perturbed, fully random
        for (phase = 0; phase < 13; phase++) begin
            case (phase % 3)
                0: begin
                    load_typical();
                end
                1: begin
                    load_typical();
                    write_cal(t_cal_idx'($urandom_range(NumCal - 1)), $urandom());
                end
                default: begin
                    load_random();
                end
            endcase
            calm  = (phase == 4);
            drain = (phase == 7);
            for (int n = 0; n < NumRand / 13; n++) begin
                logic [RawW-1:0] rt, rp;
                if ($urandom_range(3) != 0) begin
                    rt = RawW'($urandom_range(600000, 350000));
                    rp = RawW'($urandom_range(500000, 200000));
                end else begin
                    rt = RawW'($urandom());
                    rp = RawW'($urandom());
                end
                send(rt, rp, 1'b0, none_res);
                // sender holds off until everything has drained
                if (phase == 5 && n == 40) begin
                    idle_input();
                    while (pending_readings.size() != 0)
                        @(posedge i_clk);
                end
            end
            idle_input();
            calm = 1'b0;
            drain = 1'b0;
            wait_idle();
        end

        $display("covered %0d items, %0d results, reset/extreme/typical/random calibrations",
                 n_items, n_results);
        if (n_errors == 0 && pending_readings.size() == 0)
            $display("[barometric_pressure_compensation] OK");
        else
            $display("[barometric_pressure_compensation] ERROR");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #4000000;
        $display("timeout with %0d results outstanding", pending_readings.size());
        $display("[barometric_pressure_compensation] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

/* barometric_pressure_compensation.f */
rtl/core/bpc_pkg.sv
rtl/core/bpc_in_if.sv
rtl/core/bpc_out_if.sv
rtl/core/bpc_pre.sv
rtl/core/bpc_div_cell.sv
rtl/core/bpc_post.sv
rtl/core/barometric_pressure_compensation.sv
dv/tb_top.sv
